/* hw/rtl/bdn_pkg.sv */
`timescale 1ns / 1ps

package bdn_pkg;

  // Default depth of the input vector per neuron
  localparam int MAX_INPUTS_DEF = 8192;

  // Lane count of the packed words; items never use more than 32 lanes
  localparam int LANES = 32;
  localparam int LANE_LIMIT = (LANES < 32) ? LANES : 32;

  // Signed 32-bit clamp bounds, held wide so any narrower signed value compares cleanly
  localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] S32_MIN = 64'shFFFF_FFFF_8000_0000;

  // Configuration register indexes
  localparam logic REG_BINARIZE = 1'b0;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic acc_step;   // accumulate the accepted beat
    logic take_last;  // beat closes the vector: latch work values, clear accumulator
    logic step_x;     // x = sat(acc * 2^16 + bias)
    logic step_d;     // d = sat(x - mean)
    logic mul_en;     // load the shared product register
    logic mul_sel;    // 0: d * inv_std, 1: p * gamma
    logic step_p;     // p = sat(floor(prod / 2^16))
    logic step_q;     // q = sat(floor(prod / 2^16))
    logic load_out;   // y = sat(q + beta) into the output register
  } cmd_t;

endpackage

/* hw/rtl/binary_dense_neuron_bn_sign.sv */
`timescale 1ns / 1ps

// One neuron of a binarized dense layer. Each input beat carries up to 32 packed
// activation and weight sign bits; matching lanes add +1 and differing lanes -1 to a
// saturating accumulator, one beat per cycle while idle. The beat marked last adds the bias and
// runs batch normalization in Q16.16 through a shared 32x32 multiplier, stepping from
// acceptance of that beat to the result (x, d, two multiply/shift pairs, then the
// final add); the input is not ready during that pass, so the next beat is taken only once
// the pass ends, later while an earlier result still waits to be taken. One
// result beat comes out per vector, carrying the normalized value, its sign (forced to 0
// when binarize_enable is clear) and a flag that any clamp acted. A finished result waits
// in an output register while the next vector streams in. binarize_enable sits at byte
// address 0.

module binary_dense_neuron_bn_sign
  import bdn_pkg::*;
#(
  parameter int MAX_INPUTS = MAX_INPUTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        act_bits,
  input  logic [31:0]        weight_bits,
  input  logic [5:0]         lane_count,
  input  logic               last,
  input  logic signed [31:0] bias,
  input  logic signed [31:0] mean,
  input  logic signed [31:0] inv_std,
  input  logic signed [31:0] gamma,
  input  logic signed [31:0] beta,
  // output channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] norm_value,
  output logic               sign_out,
  output logic               saturated
);

  logic binarize_enable;
  cmd_t cmd;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BINARIZE) ? {31'b0, binarize_enable} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      binarize_enable <= 1'b1;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_BINARIZE)) begin
      binarize_enable <= pwdata[0];
    end
  end

  bdn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last      (last),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  bdn_datapath #(
    .MAX_INPUTS (MAX_INPUTS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .binarize_enable (binarize_enable),
    .act_bits        (act_bits),
    .weight_bits     (weight_bits),
    .lane_count      (lane_count),
    .bias            (bias),
    .mean            (mean),
    .inv_std         (inv_std),
    .gamma           (gamma),
    .beta            (beta),
    .norm_value      (norm_value),
    .sign_out        (sign_out),
    .saturated       (saturated)
  );

endmodule

/* hw/rtl/bdn_ctrl.sv */
`timescale 1ns / 1ps

module bdn_ctrl
  import bdn_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic last,
  input  logic out_ready,
  output logic in_ready,
  output logic out_valid,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_X    = 3'd1;
  localparam logic [2:0] S_D    = 3'd2;
  localparam logic [2:0] S_M1   = 3'd3;
  localparam logic [2:0] S_P    = 3'd4;
  localparam logic [2:0] S_M2   = 3'd5;
  localparam logic [2:0] S_Q    = 3'd6;
  localparam logic [2:0] S_Y    = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;
  logic       out_free;

  assign in_ready = (state == S_IDLE) && !rst;
  assign accept   = in_valid && in_ready;
  // output slot is free when empty or being drained this cycle
  assign out_free = !out_valid || out_ready;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.acc_step  = accept;
        cmd.take_last = accept && last;
        if (accept && last) begin
          state_next = S_X;
        end
      end
      S_X: begin
        cmd.step_x = 1'b1;
        state_next = S_D;
      end
      S_D: begin
        cmd.step_d = 1'b1;
        state_next = S_M1;
      end
      S_M1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = 1'b0;
        state_next  = S_P;
      end
      S_P: begin
        cmd.step_p = 1'b1;
        state_next = S_M2;
      end
      S_M2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = 1'b1;
        state_next  = S_Q;
      end
      S_Q: begin
        cmd.step_q = 1'b1;
        state_next = S_Y;
      end
      S_Y: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/bdn_datapath.sv */
`timescale 1ns / 1ps

module bdn_datapath
  import bdn_pkg::*;
#(
  parameter int MAX_INPUTS = MAX_INPUTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic               binarize_enable,
  input  logic [31:0]        act_bits,
  input  logic [31:0]        weight_bits,
  input  logic [5:0]         lane_count,
  input  logic signed [31:0] bias,
  input  logic signed [31:0] mean,
  input  logic signed [31:0] inv_std,
  input  logic signed [31:0] gamma,
  input  logic signed [31:0] beta,
  output logic signed [31:0] norm_value,
  output logic               sign_out,
  output logic               saturated
);

  // accumulator spans -2*MAX_INPUTS .. 2*MAX_INPUTS-1
  localparam int ACC_W  = $clog2(2 * MAX_INPUTS) + 1;
  localparam int ACC_W1 = ACC_W + 1;
  localparam int XW     = (ACC_W + 17 > 34) ? ACC_W + 17 : 34;
  localparam logic signed [ACC_W:0] ACC_HI = ACC_W1'(2 * MAX_INPUTS - 1);
  localparam logic signed [ACC_W:0] ACC_LO = ACC_W1'(-2 * MAX_INPUTS);

  logic signed [ACC_W-1:0] acc;
  logic                    sat_sticky;

  // work registers for the normalization pass
  logic signed [ACC_W-1:0] acc_work;
  logic                    sat_work;
  logic signed [31:0]      bias_r;
  logic signed [31:0]      mean_r;
  logic signed [31:0]      inv_std_r;
  logic signed [31:0]      gamma_r;
  logic signed [31:0]      beta_r;
  logic signed [31:0]      x_r;
  logic signed [31:0]      d_r;
  logic signed [31:0]      p_r;
  logic signed [31:0]      q_r;
  logic signed [63:0]      prod;

  // lane match count
  logic [5:0]             n_eff;
  logic [31:0]            lane_mask;
  logic [5:0]             agree_cnt;
  logic signed [7:0]      delta;
  logic signed [ACC_W:0]  acc_sum;
  logic signed [ACC_W-1:0] acc_next;
  logic                   acc_sat;

  always_comb begin
    n_eff = (lane_count > 6'(LANE_LIMIT)) ? 6'(LANE_LIMIT) : lane_count;
    for (int i = 0; i < 32; i++) begin
      lane_mask[i] = (6'(i) < n_eff);
    end
    agree_cnt = 6'($countones(~(act_bits ^ weight_bits) & lane_mask));
    delta   = $signed({1'b0, agree_cnt, 1'b0}) - $signed({2'b00, n_eff});
    acc_sum = ACC_W1'(acc) + ACC_W1'(delta);
    acc_sat = 1'b0;
    if (acc_sum > ACC_HI) begin
      acc_next = ACC_HI[ACC_W-1:0];
      acc_sat  = 1'b1;
    end else if (acc_sum < ACC_LO) begin
      acc_next = ACC_LO[ACC_W-1:0];
      acc_sat  = 1'b1;
    end else begin
      acc_next = acc_sum[ACC_W-1:0];
    end
  end

  // accumulator and sticky flag; cleared once a vector closes
  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      sat_sticky <= 1'b0;
    end else if (cmd.take_last) begin
      acc        <= '0;
      sat_sticky <= 1'b0;
    end else if (cmd.acc_step) begin
      acc        <= acc_next;
      sat_sticky <= sat_sticky | acc_sat;
    end
  end

  // normalization step values
  logic signed [XW-1:0]  x_full;
  logic signed [33:0]    d_full;
  logic signed [47:0]    prod_sh;
  logic signed [33:0]    y_full;
  logic signed [31:0]    x_val;
  logic signed [31:0]    d_val;
  logic signed [31:0]    s_val;
  logic signed [31:0]    y_val;
  logic                  x_sat;
  logic                  d_sat;
  logic                  s_sat;
  logic                  y_sat;
  logic signed [31:0]    mul_a;
  logic signed [31:0]    mul_b;

  always_comb begin
    x_full = (XW'(acc_work) <<< 16) + XW'(bias_r);
    x_sat  = (x_full > S32_MAX) || (x_full < S32_MIN);
    x_val  = (x_full > S32_MAX) ? S32_MAX[31:0] :
             (x_full < S32_MIN) ? S32_MIN[31:0] : x_full[31:0];

    d_full = 34'(x_r) - 34'(mean_r);
    d_sat  = (d_full > S32_MAX) || (d_full < S32_MIN);
    d_val  = (d_full > S32_MAX) ? S32_MAX[31:0] :
             (d_full < S32_MIN) ? S32_MIN[31:0] : d_full[31:0];

    // arithmetic shift is floor division by 2^16
    prod_sh = prod[63:16];
    s_sat   = (prod_sh > S32_MAX) || (prod_sh < S32_MIN);
    s_val   = (prod_sh > S32_MAX) ? S32_MAX[31:0] :
              (prod_sh < S32_MIN) ? S32_MIN[31:0] : prod_sh[31:0];

    y_full = 34'(q_r) + 34'(beta_r);
    y_sat  = (y_full > S32_MAX) || (y_full < S32_MIN);
    y_val  = (y_full > S32_MAX) ? S32_MAX[31:0] :
             (y_full < S32_MIN) ? S32_MIN[31:0] : y_full[31:0];

    // one shared multiplier
    mul_a = cmd.mul_sel ? p_r : d_r;
    mul_b = cmd.mul_sel ? gamma_r : inv_std_r;
  end

  // work pipeline registers
  always_ff @(posedge clk) begin
    if (cmd.take_last) begin
      acc_work  <= acc_next;
      bias_r    <= bias;
      mean_r    <= mean;
      inv_std_r <= inv_std;
      gamma_r   <= gamma;
      beta_r    <= beta;
    end
    if (cmd.step_x) begin
      x_r <= x_val;
    end
    if (cmd.step_d) begin
      d_r <= d_val;
    end
    if (cmd.mul_en) begin
      prod <= 64'(mul_a) * 64'(mul_b);
    end
    if (cmd.step_p) begin
      p_r <= s_val;
    end
    if (cmd.step_q) begin
      q_r <= s_val;
    end
    if (cmd.load_out) begin
      norm_value <= y_val;
      sign_out   <= binarize_enable && !y_val[31];
      saturated  <= sat_work | y_sat;
    end
  end

  // saturation seen anywhere in this vector's pass
  always_ff @(posedge clk) begin
    if (cmd.take_last) begin
      sat_work <= sat_sticky | acc_sat;
    end else if (cmd.step_x) begin
      sat_work <= sat_work | x_sat;
    end else if (cmd.step_d) begin
      sat_work <= sat_work | d_sat;
    end else if (cmd.step_p || cmd.step_q) begin
      sat_work <= sat_work | s_sat;
    end
  end

endmodule
